>>> rtl/tpi_pkg.sv
`default_nettype none
package tpi_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int THR_W      = 32;
    localparam int THR_SHIFT  = 3 * FRAC_BITS - 32;
    localparam int CROSS_W    = 2 * WORD_W + 1;
    localparam int SQ_W       = 2 * WORD_W;
    localparam int DET_W      = 3 * WORD_W + 3;
    localparam int SCALE_W    = 3 * WORD_W + 1;
    localparam int NUM_W      = SCALE_W + CROSS_W + 2;
    localparam int DEN_W      = DET_W + FRAC_BITS;
    localparam int PART_W     = WORD_W + 1;
    localparam int PP_W       = 2 * PART_W;
    localparam int QUO_W      = WORD_W - 1;
    localparam int DIV_STAGES = QUO_W;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(4295);

    typedef logic signed [WORD_W-1:0]  word_t;
    typedef logic signed [CROSS_W-1:0] cprod_t;
    typedef logic signed [SCALE_W-1:0] scale_t;
    typedef logic signed [DET_W-1:0]   det_t;
    typedef logic signed [NUM_W-1:0]   num_t;
    typedef logic        [NUM_W-1:0]   mag_t;
    typedef logic        [DEN_W-1:0]   den_t;
    typedef logic        [QUO_W-1:0]   quo_t;
    typedef logic signed [PP_W-1:0]    pp_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        word_t plane1_normal_x;
        word_t plane1_normal_y;
        word_t plane1_normal_z;
        word_t plane1_offset;
        word_t plane2_normal_x;
        word_t plane2_normal_y;
        word_t plane2_normal_z;
        word_t plane2_offset;
        word_t plane3_normal_x;
        word_t plane3_normal_y;
        word_t plane3_normal_z;
        word_t plane3_offset;
    } in_beat_t;

    typedef struct packed {
        word_t point_x;
        word_t point_y;
        word_t point_z;
        logic  solved;
    } out_beat_t;

    typedef struct packed {
        logic solved;
        logic det_neg;
    } numer_flags_t;

endpackage
`default_nettype wire

>>> rtl/tpi_products.sv
`default_nettype none
module tpi_products
    import tpi_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     ce,
    input  wire logic     in_valid,
    input  wire in_beat_t in_beat,
    output logic          out_valid,
    output cprod_t        cprod_out [3][3],
    output scale_t        scale_out [3],
    output det_t          det_out
);

    word_t nrm [3][3];
    word_t off [3];

    logic signed [2*WORD_W-1:0] pa_reg  [3][3];
    logic signed [2*WORD_W-1:0] pb_reg  [3][3];
    logic signed [2*WORD_W-1:0] sqp_reg [3][3];
    word_t  n0_1_reg [3];
    word_t  off_1_reg [3];

    cprod_t          cp2_reg [3][3];
    logic [SQ_W-1:0] sq2_reg [3];
    word_t           n0_2_reg [3];
    word_t           off_2_reg [3];

    cprod_t cp3_reg [3][3];
    pp_t    dlo_reg [3];
    pp_t    dhi_reg [3];
    pp_t    slo_reg [3];
    pp_t    shi_reg [3];

    cprod_t cp4_reg [3][3];
    scale_t scale4_reg [3];
    det_t   det4_reg;

    logic [3:0] vld_reg;

    always_comb begin
        nrm[0][0] = in_beat.plane1_normal_x;
        nrm[0][1] = in_beat.plane1_normal_y;
        nrm[0][2] = in_beat.plane1_normal_z;
        off[0]    = in_beat.plane1_offset;
        nrm[1][0] = in_beat.plane2_normal_x;
        nrm[1][1] = in_beat.plane2_normal_y;
        nrm[1][2] = in_beat.plane2_normal_z;
        off[1]    = in_beat.plane2_offset;
        nrm[2][0] = in_beat.plane3_normal_x;
        nrm[2][1] = in_beat.plane3_normal_y;
        nrm[2][2] = in_beat.plane3_normal_z;
        off[2]    = in_beat.plane3_offset;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    for (genvar p = 0; p < 3; p++) begin : g_plane
        localparam int A = (p + 1) % 3;
        localparam int B = (p + 2) % 3;
        for (genvar k = 0; k < 3; k++) begin : g_comp
            localparam int K1 = (k + 1) % 3;
            localparam int K2 = (k + 2) % 3;
            // stage 1: raw normal products
            always_ff @(posedge aclk) begin
                if (ce) begin
                    pa_reg[p][k]  <= nrm[A][K1] * nrm[B][K2];
                    pb_reg[p][k]  <= nrm[A][K2] * nrm[B][K1];
                    sqp_reg[p][k] <= nrm[p][k] * nrm[p][k];
                end
            end
            // stage 2: cross product components
            always_ff @(posedge aclk) begin
                if (ce) begin
                    cp2_reg[p][k] <= CROSS_W'(pa_reg[p][k]) - CROSS_W'(pb_reg[p][k]);
                    cp3_reg[p][k] <= cp2_reg[p][k];
                    cp4_reg[p][k] <= cp3_reg[p][k];
                end
            end
            assign cprod_out[p][k] = cp4_reg[p][k];
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                n0_1_reg[p]  <= nrm[0][p];
                off_1_reg[p] <= off[p];
                n0_2_reg[p]  <= n0_1_reg[p];
                off_2_reg[p] <= off_1_reg[p];
                sq2_reg[p]   <= $unsigned(sqp_reg[p][0]) + $unsigned(sqp_reg[p][1])
                              + $unsigned(sqp_reg[p][2]);
                // stage 3: split products for det and offset weight
                dlo_reg[p] <= n0_2_reg[p] * $signed({1'b0, cp2_reg[0][p][WORD_W-1:0]});
                dhi_reg[p] <= n0_2_reg[p] * $signed(cp2_reg[0][p][CROSS_W-1:WORD_W]);
                slo_reg[p] <= off_2_reg[p] * $signed({1'b0, sq2_reg[p][WORD_W-1:0]});
                shi_reg[p] <= off_2_reg[p] * $signed({1'b0, sq2_reg[p][SQ_W-1:WORD_W]});
                // stage 4
                scale4_reg[p] <= -((SCALE_W'(shi_reg[p]) <<< WORD_W) + SCALE_W'(slo_reg[p]));
            end
        end
        assign scale_out[p] = scale4_reg[p];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            det4_reg <= (DET_W'(dhi_reg[0]) <<< WORD_W) + DET_W'(dlo_reg[0])
                      + (DET_W'(dhi_reg[1]) <<< WORD_W) + DET_W'(dlo_reg[1])
                      + (DET_W'(dhi_reg[2]) <<< WORD_W) + DET_W'(dlo_reg[2]);
        end
    end

    assign det_out   = det4_reg;
    assign out_valid = vld_reg[3];

endmodule
`default_nettype wire

>>> rtl/tpi_numer.sv
`default_nettype none
module tpi_numer
    import tpi_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             ce,
    input  wire logic             in_valid,
    input  wire cprod_t           cprod_in [3][3],
    input  wire scale_t           scale_in [3],
    input  wire det_t             det_in,
    input  wire logic [THR_W-1:0] thr,
    output logic                  out_valid,
    output num_t                  num_out [3],
    output den_t                  den_out,
    output numer_flags_t          flags_out
);

    logic signed [PART_W-1:0] sp [3][3];
    logic signed [PART_W-1:0] cq [3][3][2];

    pp_t            pp5_reg [3][3][3][2];
    logic [DET_W-1:0] detabs5_reg;
    logic           detneg5_reg;

    num_t           prod6_reg [3][3];
    logic [DET_W-1:0] detabs6_reg;
    logic           detneg6_reg;
    logic           solved6_reg;

    num_t           num7_reg [3];
    den_t           den7_reg;
    numer_flags_t   flags7_reg;

    logic [2:0]     vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    for (genvar p = 0; p < 3; p++) begin : g_split
        assign sp[p][0] = $signed({1'b0, scale_in[p][WORD_W-1:0]});
        assign sp[p][1] = $signed({1'b0, scale_in[p][2*WORD_W-1:WORD_W]});
        assign sp[p][2] = scale_in[p][SCALE_W-1:2*WORD_W];
        for (genvar k = 0; k < 3; k++) begin : g_c
            assign cq[p][k][0] = $signed({1'b0, cprod_in[p][k][WORD_W-1:0]});
            assign cq[p][k][1] = cprod_in[p][k][CROSS_W-1:WORD_W];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_coord
        for (genvar p = 0; p < 3; p++) begin : g_term
            for (genvar i = 0; i < 3; i++) begin : g_i
                for (genvar j = 0; j < 2; j++) begin : g_j
                    always_ff @(posedge aclk) begin
                        if (ce) begin
                            pp5_reg[k][p][i][j] <= sp[p][i] * cq[p][k][j];
                        end
                    end
                end
            end
            always_ff @(posedge aclk) begin
                if (ce) begin
                    prod6_reg[k][p] <= NUM_W'(pp5_reg[k][p][0][0])
                        + (NUM_W'(pp5_reg[k][p][0][1]) <<< WORD_W)
                        + (NUM_W'(pp5_reg[k][p][1][0]) <<< WORD_W)
                        + (NUM_W'(pp5_reg[k][p][1][1]) <<< (2 * WORD_W))
                        + (NUM_W'(pp5_reg[k][p][2][0]) <<< (2 * WORD_W))
                        + (NUM_W'(pp5_reg[k][p][2][1]) <<< (3 * WORD_W));
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                num7_reg[k] <= prod6_reg[k][0] + prod6_reg[k][1] + prod6_reg[k][2];
            end
        end
        assign num_out[k] = num7_reg[k];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            detabs5_reg <= det_in[DET_W-1] ? DET_W'(-det_in) : DET_W'(det_in);
            detneg5_reg <= det_in[DET_W-1];
            detabs6_reg <= detabs5_reg;
            detneg6_reg <= detneg5_reg;
            solved6_reg <= detabs5_reg > DET_W'({thr, {THR_SHIFT{1'b0}}});
            den7_reg    <= {detabs6_reg, {FRAC_BITS{1'b0}}};
            flags7_reg.solved  <= solved6_reg;
            flags7_reg.det_neg <= detneg6_reg;
        end
    end

    assign den_out   = den7_reg;
    assign flags_out = flags7_reg;
    assign out_valid = vld_reg[2];

endmodule
`default_nettype wire

>>> rtl/tpi_divider.sv
`default_nettype none
module tpi_divider
    import tpi_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         ce,
    input  wire logic         in_valid,
    input  wire num_t         num_in [3],
    input  wire den_t         den_in,
    input  wire numer_flags_t flags_in,
    output logic              out_valid,
    output quo_t              quo_out [3],
    output logic              sat_out [3],
    output logic              neg_out [3],
    output logic              solved_out
);

    mag_t mag8_reg [3];
    logic neg8_reg [3];
    den_t den8_reg;
    logic solved8_reg;
    logic vld8_reg;

    mag_t rem_reg    [DIV_STAGES+1][3];
    quo_t quo_reg    [DIV_STAGES+1][3];
    logic sat_reg    [DIV_STAGES+1][3];
    logic neg_reg    [DIV_STAGES+1][3];
    den_t den_reg    [DIV_STAGES+1];
    logic solved_reg [DIV_STAGES+1];
    logic vld_reg    [DIV_STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld8_reg   <= 1'b0;
            vld_reg[0] <= 1'b0;
        end else if (ce) begin
            vld8_reg   <= in_valid;
            vld_reg[0] <= vld8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            den8_reg      <= den_in;
            solved8_reg   <= flags_in.solved;
            den_reg[0]    <= den8_reg;
            solved_reg[0] <= solved8_reg;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_abs
        always_ff @(posedge aclk) begin
            if (ce) begin
                mag8_reg[k]   <= num_in[k][NUM_W-1] ? NUM_W'(-num_in[k]) : NUM_W'(num_in[k]);
                neg8_reg[k]   <= num_in[k][NUM_W-1] ^ flags_in.det_neg;
                // quotient overflow check against den * 2^31
                sat_reg[0][k] <= mag8_reg[k] >= (NUM_W'(den8_reg) << QUO_W);
                rem_reg[0][k] <= mag8_reg[k];
                quo_reg[0][k] <= '0;
                neg_reg[0][k] <= neg8_reg[k];
            end
        end
    end

    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
        localparam int B = DIV_STAGES - s;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (ce) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                den_reg[s]    <= den_reg[s-1];
                solved_reg[s] <= solved_reg[s-1];
            end
        end

        for (genvar k = 0; k < 3; k++) begin : g_lane
            mag_t dsh;
            logic hit;
            assign dsh = NUM_W'(den_reg[s-1]) << B;
            assign hit = rem_reg[s-1][k] >= dsh;
            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[s][k] <= hit ? rem_reg[s-1][k] - dsh : rem_reg[s-1][k];
                    quo_reg[s][k] <= quo_reg[s-1][k] | (hit ? (QUO_W'(1) << B) : '0);
                    sat_reg[s][k] <= sat_reg[s-1][k];
                    neg_reg[s][k] <= neg_reg[s-1][k];
                end
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_out
        assign quo_out[k] = quo_reg[DIV_STAGES][k];
        assign sat_out[k] = sat_reg[DIV_STAGES][k];
        assign neg_out[k] = neg_reg[DIV_STAGES][k];
    end

    assign solved_out = solved_reg[DIV_STAGES];
    assign out_valid  = vld_reg[DIV_STAGES];

endmodule
`default_nettype wire

>>> rtl/three_plane_intersection.sv
// channel   | ports                          | contents
// ----------+--------------------------------+------------------------------------
// input     | s_valid, s_ready, s_beat       | three planes, normal and offset
// result    | m_valid, m_ready, m_beat       | point x/y/z and solved flag
// config    | det_threshold_we/_wdata        | determinant limit, write only
//
// one beat per cycle in and out while the result is not stalled
// the 31-step restoring divider resolves one quotient bit per stage
// reset is synchronous; threshold returns to 4295, all valid bits clear
// a stalled result holds the whole pipeline, nothing is dropped or repeated
`default_nettype none
module three_plane_intersection
    import tpi_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_beat_t         s_beat,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_beat_t             m_beat,
    input  wire logic             det_threshold_we,
    input  wire logic [THR_W-1:0] det_threshold_wdata
);

    logic             ce;
    logic [THR_W-1:0] det_threshold_reg;

    logic         prod_valid;
    cprod_t       prod_cp [3][3];
    scale_t       prod_scale [3];
    det_t         prod_det;

    logic         numer_valid;
    num_t         numer_num [3];
    den_t         numer_den;
    numer_flags_t numer_flags;

    logic         div_valid;
    quo_t         div_quo [3];
    logic         div_sat [3];
    logic         div_neg [3];
    logic         div_solved;

    word_t        pt [3];
    logic         m_valid_reg;
    out_beat_t    m_beat_reg;

    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_threshold_reg <= THR_RESET;
        end else if (det_threshold_we) begin
            det_threshold_reg <= det_threshold_wdata;
        end
    end

    tpi_products u_products (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .in_beat   (s_beat),
        .out_valid (prod_valid),
        .cprod_out (prod_cp),
        .scale_out (prod_scale),
        .det_out   (prod_det)
    );

    tpi_numer u_numer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (prod_valid),
        .cprod_in  (prod_cp),
        .scale_in  (prod_scale),
        .det_in    (prod_det),
        .thr       (det_threshold_reg),
        .out_valid (numer_valid),
        .num_out   (numer_num),
        .den_out   (numer_den),
        .flags_out (numer_flags)
    );

    tpi_divider u_divider (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .in_valid   (numer_valid),
        .num_in     (numer_num),
        .den_in     (numer_den),
        .flags_in   (numer_flags),
        .out_valid  (div_valid),
        .quo_out    (div_quo),
        .sat_out    (div_sat),
        .neg_out    (div_neg),
        .solved_out (div_solved)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!div_solved) begin
                pt[k] = '0;
            end else if (div_sat[k]) begin
                pt[k] = div_neg[k] ? WORD_MIN : WORD_MAX;
            end else begin
                pt[k] = div_neg[k] ? -$signed(WORD_W'(div_quo[k]))
                                   : $signed(WORD_W'(div_quo[k]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_beat_reg.point_x <= pt[0];
            m_beat_reg.point_y <= pt[1];
            m_beat_reg.point_z <= pt[2];
            m_beat_reg.solved  <= div_solved;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

    a_unsolved_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_beat.solved |->
            m_beat.point_x == '0 && m_beat.point_y == '0 && m_beat.point_z == '0)
        else $error("unsolved beat carries a nonzero point");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire

>>> tb/three_plane_intersection_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module three_plane_intersection_checker
    import tpi_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_ready,
    input  wire in_beat_t         s_beat,
    input  wire logic             m_valid,
    input  wire logic             m_ready,
    input  wire out_beat_t        m_beat,
    input  wire logic             det_threshold_we,
    input  wire logic [THR_W-1:0] det_threshold_wdata,
    output int                    fail_count,
    output int                    pending_points
);

    typedef logic signed [383:0] wide_t;

    logic [THR_W-1:0] thr_shadow;
    out_beat_t        point_queue[$];

    function automatic word_t quotient_sat(wide_t num, wide_t den);
        wide_t q;
        wide_t lim;
        logic  neg;
        neg = num[383] ^ den[383];
        q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
        lim = wide_t'(1) <<< (WORD_W - 1);
        if (q >= lim) return neg ? WORD_MIN : WORD_MAX;
        return neg ? word_t'(-q) : word_t'(q);
    endfunction

    function automatic out_beat_t solve_point(in_beat_t b, logic [THR_W-1:0] thr);
        wide_t     n[3][3];
        wide_t     off[3];
        wide_t     c[3][3];
        wide_t     s[3];
        wide_t     det;
        wide_t     num;
        wide_t     adet;
        out_beat_t r;
        int        a;
        int        q;
        n[0][0] = b.plane1_normal_x; n[0][1] = b.plane1_normal_y;
        n[0][2] = b.plane1_normal_z; off[0] = b.plane1_offset;
        n[1][0] = b.plane2_normal_x; n[1][1] = b.plane2_normal_y;
        n[1][2] = b.plane2_normal_z; off[1] = b.plane2_offset;
        n[2][0] = b.plane3_normal_x; n[2][1] = b.plane3_normal_y;
        n[2][2] = b.plane3_normal_z; off[2] = b.plane3_offset;
        for (int p = 0; p < 3; p++) begin
            a = (p + 1) % 3;
            q = (p + 2) % 3;
            c[p][0] = n[a][1] * n[q][2] - n[a][2] * n[q][1];
            c[p][1] = n[a][2] * n[q][0] - n[a][0] * n[q][2];
            c[p][2] = n[a][0] * n[q][1] - n[a][1] * n[q][0];
            s[p] = -(off[p] * (n[p][0] * n[p][0] + n[p][1] * n[p][1]
                               + n[p][2] * n[p][2]));
        end
        det = n[0][0] * c[0][0] + n[0][1] * c[0][1] + n[0][2] * c[0][2];
        adet = det < 0 ? -det : det;
        r = '0;
        if (adet <= (wide_t'({1'b0, thr}) <<< THR_SHIFT)) return r;
        num = s[0] * c[0][0] + s[1] * c[1][0] + s[2] * c[2][0];
        r.point_x = quotient_sat(num, det <<< FRAC_BITS);
        num = s[0] * c[0][1] + s[1] * c[1][1] + s[2] * c[2][1];
        r.point_y = quotient_sat(num, det <<< FRAC_BITS);
        num = s[0] * c[0][2] + s[1] * c[1][2] + s[2] * c[2][2];
        r.point_z = quotient_sat(num, det <<< FRAC_BITS);
        r.solved = 1'b1;
        return r;
    endfunction

    assign pending_points = point_queue.size();

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            thr_shadow <= THR_RESET;
            fail_count <= 0;
            point_queue.delete();
        end else begin
            if (det_threshold_we) thr_shadow <= det_threshold_wdata;
            if (s_valid && s_ready) point_queue.push_back(solve_point(s_beat, thr_shadow));
            if (m_valid && m_ready) begin
                if (point_queue.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result beat %h", m_beat);
                    fail_count <= fail_count + 1;
                end else begin
                    want = point_queue.pop_front();
                    if (want !== m_beat) begin
                        if (fail_count < 10)
                            $display("mismatch: exp x=%h y=%h z=%h s=%b got x=%h y=%h z=%h s=%b",
                                     want.point_x, want.point_y, want.point_z, want.solved,
                                     m_beat.point_x, m_beat.point_y, m_beat.point_z,
                                     m_beat.solved);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> tb/three_plane_intersection_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module three_plane_intersection_tb;
    import tpi_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    in_beat_t         s_beat = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_beat_t        m_beat;
    logic             det_threshold_we = 1'b0;
    logic [THR_W-1:0] det_threshold_wdata = '0;
    int               fail_count;
    int               pending_points;
    int               idle_cycles = 0;
    int               burst_left = 0;
    int               stall_mode = 0;

    always #2 aclk = ~aclk;

    three_plane_intersection uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_beat(s_beat),
        .m_valid(m_valid), .m_ready(m_ready), .m_beat(m_beat),
        .det_threshold_we(det_threshold_we), .det_threshold_wdata(det_threshold_wdata)
    );

    three_plane_intersection_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_beat(s_beat),
        .m_valid(m_valid), .m_ready(m_ready), .m_beat(m_beat),
        .det_threshold_we(det_threshold_we), .det_threshold_wdata(det_threshold_wdata),
        .fail_count(fail_count), .pending_points(pending_points)
    );

    // receiver stall pattern, changes mode now and then
    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ~m_ready;
        endcase
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic word_t pick_word(int kind);
        case ($urandom_range(0, kind))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return word_t'($urandom_range(0, 4) - 2) <<< 16;
            3: return word_t'($signed($urandom_range(0, 131071)) - 65536);
            4: return word_t'($signed($urandom_range(0, 8388607)) - 4194304);
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic in_beat_t random_planes();
        in_beat_t b;
        int       kind;
        kind = $urandom_range(2, 7);
        b = {pick_word(kind), pick_word(kind), pick_word(kind), pick_word(kind),
             pick_word(kind), pick_word(kind), pick_word(kind), pick_word(kind),
             pick_word(kind), pick_word(kind), pick_word(kind), pick_word(kind)};
        // sometimes make plane 3 parallel to plane 1
        if ($urandom_range(0, 9) == 0) begin
            b.plane3_normal_x = b.plane1_normal_x;
            b.plane3_normal_y = b.plane1_normal_y;
            b.plane3_normal_z = b.plane1_normal_z;
        end
        return b;
    endfunction

    task automatic send_beat(in_beat_t b);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        s_valid <= 1'b1;
        s_beat  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        s_valid <= 1'b0;
        while (pending_points != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        det_threshold_we    <= 1'b1;
        det_threshold_wdata <= v;
        @(negedge aclk);
        det_threshold_we <= 1'b0;
        burst_left = 0;
    endtask

    initial begin
        in_beat_t b;
        logic [THR_W-1:0] thr_set[5];
        thr_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000, THR_RESET};
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: identity, extremes, degenerate, non-unit normals
        b = '0;
        b.plane1_normal_x = 32'sh10000; b.plane1_offset = -32'sh20000;
        b.plane2_normal_y = 32'sh10000; b.plane2_offset = 32'sh30000;
        b.plane3_normal_z = 32'sh10000; b.plane3_offset = 32'sh8000;
        send_beat(b);
        b.plane1_normal_x = 32'sh30000; send_beat(b);
        b.plane3_offset = WORD_MAX; send_beat(b);
        b.plane3_offset = WORD_MIN; send_beat(b);
        b.plane3_normal_z = 32'sh1; send_beat(b);
        b.plane3_normal_z = 32'sh0; send_beat(b);
        send_beat('0);
        send_beat({12{WORD_MAX}});
        send_beat({12{WORD_MIN}});
        send_beat({12{32'hFFFF_FFFF}});
        b = {WORD_MAX, WORD_MIN, 32'sh1, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN,
             32'sh1, WORD_MIN, WORD_MAX, WORD_MAX};
        send_beat(b);
        b = {32'sh1, 32'sh0, 32'sh0, WORD_MAX, 32'sh0, 32'sh1, 32'sh0, WORD_MIN,
             32'sh0, 32'sh0, 32'sh1, WORD_MAX};
        send_beat(b);
        for (int i = 0; i < 8; i++) send_beat(random_planes());

        for (int ph = 0; ph < 5; ph++) begin
            write_threshold(thr_set[ph]);
            for (int i = 0; i < 400; i++) begin
                if ($urandom_range(0, 3) == 0)
                    write_threshold(ph == 2 ? $urandom : thr_set[ph]);
                else send_beat(random_planes());
            end
        end

        s_valid <= 1'b0;
        while (pending_points != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
